>>> design/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types and constants of the ray / sphere nearest hit core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsnh_pkg;

   // fixed point format of center, radius, direction and distance
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int DIST_W  = 31;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // datapath widths
   localparam int A_W     = 64;                  // a = d.d and |h|, |c|
   localparam int DISC_W  = 128;                 // discriminant
   localparam int ROOT_W  = DISC_W / 2;          // floor(sqrt(disc))
   localparam int SREM_W  = ROOT_W + 2;          // square root remainder
   localparam int NUM_W   = A_W + 1;             // |h -/+ s|
   localparam int DVD_W   = NUM_W + FRAC_BITS;   // scaled numerator
   localparam int SAT_W   = A_W + DIST_W;        // a * 2^31
   localparam int REM_W   = (DVD_W > SAT_W) ? DVD_W : SAT_W;

   // pipeline step counts
   localparam int SQ_STEPS  = ROOT_W;
   localparam int DIV_STEPS = DIST_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/ray_sphere_nearest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit_core
// Nearest non-negative hit of a ray from the origin against one sphere.
// ----------------------------------------------------------------------------
// One ray enters per clock and one result leaves per clock in order, unless the
// result side stalls. The path holds six stages of products and sums
// for the quadratic and its discriminant, a 64-stage square root pipeline
// (one root bit per stage), one stage forming the numerator, one saturation
// stage, a 31-stage divider pipeline (one quotient bit per stage) and the
// output register. A stall on the result side freezes the whole pipeline.
// Sphere registers may only be written while no ray is in flight.
`default_nettype none

module ray_sphere_nearest_hit_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire rsnh_pkg::req_type             req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      rsnh_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [rsnh_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rsnh_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int AW = rsnh_pkg::A_W;

   typedef struct packed {
      logic              vld;
      logic [AW-1:0]     dd0, dd1, dd2;
      logic signed [AW-1:0] cd0, cd1, cd2;
      logic [AW-1:0]     cc0, cc1, cc2;
      logic [2*rsnh_pkg::RAD_W-1:0] rr;
   } s1_type;

   typedef struct packed {
      logic                 vld;
      logic [AW-1:0]        a;
      logic signed [AW+1:0] h;
      logic signed [AW+1:0] cdiff;
   } s2_type;

   typedef struct packed {
      logic          vld;
      logic [AW-1:0] a;
      logic          hneg;
      logic [AW-1:0] hmag;
      logic          cneg;
      logic [AW-1:0] cmag;
   } s3_type;

   typedef struct packed {
      logic          vld;
      logic [AW-1:0] a;
      logic          hneg;
      logic [AW-1:0] hmag;
      logic          cneg;
      logic          cmzero;
      logic [AW-1:0] hp_ll, hp_lh, hp_hh;
      logic [AW-1:0] ap_ll, ap_lh, ap_hl, ap_hh;
   } s4_type;

   typedef struct packed {
      logic          vld;
      logic [AW-1:0] a;
      logic          hneg;
      logic [AW-1:0] hmag;
      logic          cneg;
      logic          cmzero;
      logic [rsnh_pkg::DISC_W-1:0] h2;
      logic [rsnh_pkg::DISC_W-1:0] ac;
   } s5_type;

   typedef struct packed {
      logic          vld;
      logic          miss;
      logic [AW-1:0] a;
      logic          hneg;
      logic          cneg;
      logic [AW-1:0] hmag;
      logic [rsnh_pkg::DISC_W-1:0] rad;
      logic [rsnh_pkg::SREM_W-1:0] rem;
      logic [rsnh_pkg::ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic          vld;
      logic          miss;
      logic [AW-1:0] a;
      logic [rsnh_pkg::NUM_W-1:0] num;
   } nm_type;

   typedef struct packed {
      logic          vld;
      logic          miss;
      logic          sat;
      logic [AW-1:0] a;
      logic [rsnh_pkg::REM_W-1:0]  rem;
      logic [rsnh_pkg::DIST_W-1:0] quo;
   } dv_type;

   // sphere registers
   logic signed [rsnh_pkg::COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [rsnh_pkg::RAD_W-1:0]          radius_ff;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   sq_type sq_ff [0:rsnh_pkg::SQ_STEPS];
   sq_type sq_in [0:rsnh_pkg::SQ_STEPS];
   nm_type nm_ff, nm_in;
   dv_type dv_ff [0:rsnh_pkg::DIV_STEPS];
   dv_type dv_in [0:rsnh_pkg::DIV_STEPS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsnh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic adv;

   // whole pipeline moves unless a finished result is held back
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rsnh_pkg::CSR_CENTER_X: center_x_ff <= $signed(csr_wdata);
            rsnh_pkg::CSR_CENTER_Y: center_y_ff <= $signed(csr_wdata);
            rsnh_pkg::CSR_CENTER_Z: center_z_ff <= $signed(csr_wdata);
            rsnh_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[rsnh_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: component products
   always_comb begin
      s1_in.vld = req_valid;
      s1_in.dd0 = $signed(req_data.dir_x) * $signed(req_data.dir_x);
      s1_in.dd1 = $signed(req_data.dir_y) * $signed(req_data.dir_y);
      s1_in.dd2 = $signed(req_data.dir_z) * $signed(req_data.dir_z);
      s1_in.cd0 = $signed(req_data.dir_x) * center_x_ff;
      s1_in.cd1 = $signed(req_data.dir_y) * center_y_ff;
      s1_in.cd2 = $signed(req_data.dir_z) * center_z_ff;
      s1_in.cc0 = center_x_ff * center_x_ff;
      s1_in.cc1 = center_y_ff * center_y_ff;
      s1_in.cc2 = center_z_ff * center_z_ff;
      s1_in.rr  = (2*rsnh_pkg::RAD_W)'(radius_ff) * (2*rsnh_pkg::RAD_W)'(radius_ff);
   end

   // stage 2: a, h = C.d, c = C.C - r*r
   always_comb begin
      s2_in.vld   = s1_ff.vld;
      s2_in.a     = s1_ff.dd0 + s1_ff.dd1 + s1_ff.dd2;
      s2_in.h     = (AW+2)'(s1_ff.cd0) + (AW+2)'(s1_ff.cd1) + (AW+2)'(s1_ff.cd2);
      s2_in.cdiff = $signed((AW+2)'(s1_ff.cc0) + (AW+2)'(s1_ff.cc1)
                            + (AW+2)'(s1_ff.cc2) - (AW+2)'(s1_ff.rr));
   end

   // stage 3: sign and magnitude of h and c
   always_comb begin
      s3_in.vld  = s2_ff.vld;
      s3_in.a    = s2_ff.a;
      s3_in.hneg = s2_ff.h < 0;
      s3_in.hmag = s3_in.hneg ? AW'(-s2_ff.h) : AW'(s2_ff.h);
      s3_in.cneg = s2_ff.cdiff < 0;
      s3_in.cmag = s3_in.cneg ? AW'(-s2_ff.cdiff) : AW'(s2_ff.cdiff);
   end

   // stage 4: 32 x 32 partial products of h*h and a*c
   always_comb begin
      s4_in.vld    = s3_ff.vld;
      s4_in.a      = s3_ff.a;
      s4_in.hneg   = s3_ff.hneg;
      s4_in.hmag   = s3_ff.hmag;
      s4_in.cneg   = s3_ff.cneg;
      s4_in.cmzero = s3_ff.cmag == '0;
      s4_in.hp_ll  = AW'(s3_ff.hmag[AW/2-1:0]) * AW'(s3_ff.hmag[AW/2-1:0]);
      s4_in.hp_lh  = AW'(s3_ff.hmag[AW/2-1:0]) * AW'(s3_ff.hmag[AW-1:AW/2]);
      s4_in.hp_hh  = AW'(s3_ff.hmag[AW-1:AW/2]) * AW'(s3_ff.hmag[AW-1:AW/2]);
      s4_in.ap_ll  = AW'(s3_ff.a[AW/2-1:0]) * AW'(s3_ff.cmag[AW/2-1:0]);
      s4_in.ap_lh  = AW'(s3_ff.a[AW/2-1:0]) * AW'(s3_ff.cmag[AW-1:AW/2]);
      s4_in.ap_hl  = AW'(s3_ff.a[AW-1:AW/2]) * AW'(s3_ff.cmag[AW/2-1:0]);
      s4_in.ap_hh  = AW'(s3_ff.a[AW-1:AW/2]) * AW'(s3_ff.cmag[AW-1:AW/2]);
   end

   // stage 5: sum the partial products
   always_comb begin
      s5_in.vld    = s4_ff.vld;
      s5_in.a      = s4_ff.a;
      s5_in.hneg   = s4_ff.hneg;
      s5_in.hmag   = s4_ff.hmag;
      s5_in.cneg   = s4_ff.cneg;
      s5_in.cmzero = s4_ff.cmzero;
      s5_in.h2 = (rsnh_pkg::DISC_W'(s4_ff.hp_hh) << AW)
               + (rsnh_pkg::DISC_W'(s4_ff.hp_lh) << (AW/2 + 1))
               + rsnh_pkg::DISC_W'(s4_ff.hp_ll);
      s5_in.ac = (rsnh_pkg::DISC_W'(s4_ff.ap_hh) << AW)
               + (rsnh_pkg::DISC_W'(s4_ff.ap_lh) << (AW/2))
               + (rsnh_pkg::DISC_W'(s4_ff.ap_hl) << (AW/2))
               + rsnh_pkg::DISC_W'(s4_ff.ap_ll);
   end

   // stage 6 seeds the root pipeline, then one root bit per stage
   always_comb begin
      logic [rsnh_pkg::SREM_W+1:0] rem_t;
      logic [rsnh_pkg::SREM_W+1:0] trial;
      // discriminant and miss decision
      sq_in[0].vld  = s5_ff.vld;
      sq_in[0].a    = s5_ff.a;
      sq_in[0].hneg = s5_ff.hneg;
      sq_in[0].cneg = s5_ff.cneg;
      sq_in[0].hmag = s5_ff.hmag;
      sq_in[0].rad  = s5_ff.cneg ? s5_ff.h2 + s5_ff.ac : s5_ff.h2 - s5_ff.ac;
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      // zero direction, negative discriminant, or both roots behind the origin
      sq_in[0].miss = (s5_ff.a == '0)
                    || (!s5_ff.cneg && (s5_ff.ac > s5_ff.h2))
                    || (s5_ff.hneg && !s5_ff.cneg && !s5_ff.cmzero);
      // square root steps
      for (int k = 1; k <= rsnh_pkg::SQ_STEPS; k++) begin
         sq_in[k] = sq_ff[k-1];
         rem_t = {sq_ff[k-1].rem, sq_ff[k-1].rad[rsnh_pkg::DISC_W-1 -: 2]};
         trial = {2'b00, sq_ff[k-1].root, 2'b01};
         sq_in[k].rad = sq_ff[k-1].rad << 2;
         if (rem_t >= trial) begin
            sq_in[k].rem  = rsnh_pkg::SREM_W'(rem_t - trial);
            sq_in[k].root = {sq_ff[k-1].root[rsnh_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k].rem  = rsnh_pkg::SREM_W'(rem_t);
            sq_in[k].root = {sq_ff[k-1].root[rsnh_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   // numerator of the nearest non-negative root
   always_comb begin
      logic [rsnh_pkg::NUM_W-1:0] hm;
      logic [rsnh_pkg::NUM_W-1:0] sr;
      hm = rsnh_pkg::NUM_W'(sq_ff[rsnh_pkg::SQ_STEPS].hmag);
      sr = rsnh_pkg::NUM_W'(sq_ff[rsnh_pkg::SQ_STEPS].root);
      nm_in.vld  = sq_ff[rsnh_pkg::SQ_STEPS].vld;
      nm_in.miss = sq_ff[rsnh_pkg::SQ_STEPS].miss;
      nm_in.a    = sq_ff[rsnh_pkg::SQ_STEPS].a;
      if (sq_ff[rsnh_pkg::SQ_STEPS].hneg)
         nm_in.num = sr - hm;
      else if (sq_ff[rsnh_pkg::SQ_STEPS].cneg)
         nm_in.num = hm + sr;
      else
         nm_in.num = hm - sr;
   end

   // saturation check seeds the divider, then one quotient bit per stage
   always_comb begin
      logic [rsnh_pkg::REM_W-1:0] dsh;
      dv_in[0].vld  = nm_ff.vld;
      dv_in[0].miss = nm_ff.miss;
      dv_in[0].a    = nm_ff.a;
      dv_in[0].rem  = rsnh_pkg::REM_W'(nm_ff.num) << rsnh_pkg::FRAC_BITS;
      dv_in[0].quo  = '0;
      dv_in[0].sat  = dv_in[0].rem >= (rsnh_pkg::REM_W'(nm_ff.a) << rsnh_pkg::DIST_W);
      // restoring divider, msb first
      for (int k = 1; k <= rsnh_pkg::DIV_STEPS; k++) begin
         dv_in[k] = dv_ff[k-1];
         dsh = rsnh_pkg::REM_W'(dv_ff[k-1].a) << (rsnh_pkg::DIV_STEPS - k);
         if (dv_ff[k-1].rem >= dsh) begin
            dv_in[k].rem = dv_ff[k-1].rem - dsh;
            dv_in[k].quo = {dv_ff[k-1].quo[rsnh_pkg::DIST_W-2:0], 1'b1};
         end else begin
            dv_in[k].quo = {dv_ff[k-1].quo[rsnh_pkg::DIST_W-2:0], 1'b0};
         end
      end
   end

   // result formatting
   always_comb begin
      rsp_valid_in = dv_ff[rsnh_pkg::DIV_STEPS].vld;
      rsp_data_in.hit       = !dv_ff[rsnh_pkg::DIV_STEPS].miss;
      rsp_data_in.saturated = !dv_ff[rsnh_pkg::DIV_STEPS].miss
                              && dv_ff[rsnh_pkg::DIV_STEPS].sat;
      if (dv_ff[rsnh_pkg::DIV_STEPS].miss)
         rsp_data_in.distance = '0;
      else if (dv_ff[rsnh_pkg::DIV_STEPS].sat)
         rsp_data_in.distance = rsnh_pkg::DIST_MAX;
      else
         rsp_data_in.distance = dv_ff[rsnh_pkg::DIV_STEPS].quo;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
         s5_ff.vld <= 1'b0;
         for (int k = 0; k <= rsnh_pkg::SQ_STEPS; k++) sq_ff[k].vld <= 1'b0;
         nm_ff.vld <= 1'b0;
         for (int k = 0; k <= rsnh_pkg::DIV_STEPS; k++) dv_ff[k].vld <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         for (int k = 0; k <= rsnh_pkg::SQ_STEPS; k++) sq_ff[k] <= sq_in[k];
         nm_ff <= nm_in;
         for (int k = 0; k <= rsnh_pkg::DIV_STEPS; k++) dv_ff[k] <= dv_in[k];
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> design/rsnh_checker.sv
// ----------------------------------------------------------------------------
// rsnh_checker
// Port-level checks of the ray / sphere nearest hit core.
// ----------------------------------------------------------------------------
`default_nettype none

module rsnh_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rsnh_pkg::rsp_type rsp_data
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");

   // input side only stalls when the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free output");

   // a miss carries zero distance and no saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.distance == '0 && !rsp_data.saturated)
      else $error("miss with nonzero fields");

   // saturation only on a hit at full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.hit && rsp_data.distance == rsnh_pkg::DIST_MAX)
      else $error("bad saturated result");

endmodule

bind ray_sphere_nearest_hit_core rsnh_checker u_rsnh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
